// ===== design/wrhp_pkg.sv =====
// Shared types and constants for the WAV RIFF header parser.
package wrhp_pkg;

	localparam int OFFSET_BITS_DEF = 32;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	localparam logic [1:0] REG_FORMAT   = 2'd0;
	localparam logic [1:0] REG_CHANNELS = 2'd1;
	localparam logic [1:0] REG_RATE     = 2'd2;
	localparam logic [1:0] REG_BITS     = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SMALL    = 3'd1;
	localparam logic [2:0] ST_MAGIC    = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_FMT      = 3'd4;
	localparam logic [2:0] ST_MISSING  = 3'd5;
	localparam logic [2:0] ST_UNSUP    = 3'd6;
	localparam logic [2:0] ST_DATA     = 3'd7;

	typedef struct packed {
		logic        accepted;
		logic [2:0]  status;
		logic [15:0] audio_format;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [15:0] sample_bits;
		logic [31:0] payload_offset;
		logic [31:0] payload_size;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic        stall;
	} link_t;

endpackage

// ===== design/wrhp_front.sv =====
// Front part: byte parser that classifies each beat and builds the result at the last byte.
module wrhp_front #(
	parameter int OFFSET_BITS = wrhp_pkg::OFFSET_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          byte_in,
	input  logic                last_byte,
	input  logic [15:0]         exp_format,
	input  logic [15:0]         exp_channels,
	input  logic [31:0]         exp_rate,
	input  logic [15:0]         exp_bits,
	output wrhp_pkg::result_t   res,
	output logic                res_push
);

	typedef enum logic [2:0] {PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG, PH_CSIZE, PH_PAY} phase_t;
	typedef enum logic [1:0] {K_OTHER, K_FMT, K_DATA} kind_t;

	phase_t                 phase_q;
	kind_t                  kind_q;
	logic [1:0]             fcnt_q;
	logic [31:0]            tag_q;
	logic [31:0]            len_q;
	logic [32:0]            left_q;
	logic [3:0]             idx_q;
	logic                   idx_sat_q;
	logic                   fmt_q, data_q;
	logic [15:0]            fmt_v_q, ch_q, bits_q;
	logic [31:0]            rate_q, dstart_q, dlen_q;
	logic [2:0]             err_q;
	logic [OFFSET_BITS-1:0] pos_q;

	logic [OFFSET_BITS-1:0] pos_n;
	logic [31:0]            tag_n, len_n;
	logic [32:0]            left_n;
	logic [31:0]            pos32;
	assign pos_n = pos_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
	assign tag_n = {tag_q[23:0], byte_in};
	assign len_n = {byte_in, len_q[31:8]};
	assign left_n = {1'b0, len_n} + {32'd0, len_n[0]};
	assign pos32 = 32'(pos_n);

	phase_t      ph_f;
	logic [2:0]  err_f;
	logic        fmt_f, data_f;
	logic [15:0] fv_f, ch_f, bt_f;
	logic [31:0] rt_f, ds_f, dl_f, ln_f;
	logic [32:0] lf_f;

	always_comb begin
		ph_f = phase_q; err_f = err_q; fmt_f = fmt_q; data_f = data_q;
		fv_f = fmt_v_q; ch_f = ch_q; rt_f = rate_q; bt_f = bits_q;
		ds_f = dstart_q; dl_f = dlen_q; ln_f = len_q; lf_f = left_q;
		case (phase_q)
			PH_RIFF: if (fcnt_q == 2'd3) begin
				if (tag_n != wrhp_pkg::TAG_RIFF && err_f == wrhp_pkg::ST_OK) err_f = wrhp_pkg::ST_MAGIC;
				ph_f = PH_RSIZE;
			end
			PH_RSIZE: if (fcnt_q == 2'd3) ph_f = PH_WAVE;
			PH_WAVE: if (fcnt_q == 2'd3) begin
				if (tag_n != wrhp_pkg::TAG_WAVE && err_f == wrhp_pkg::ST_OK) err_f = wrhp_pkg::ST_MAGIC;
				ph_f = PH_CTAG;
			end
			PH_CTAG: if (fcnt_q == 2'd3) begin
				ph_f = PH_CSIZE;
				ln_f = '0;
			end
			PH_CSIZE: begin
				ln_f = len_n;
				if (fcnt_q == 2'd3) begin
					lf_f = left_n;
					if (kind_q == K_FMT) begin
						if (len_n < 32'd16) begin
							if (err_f == wrhp_pkg::ST_OK) err_f = wrhp_pkg::ST_FMT;
						end else fmt_f = 1'b1;
					end else if (kind_q == K_DATA) begin
						data_f = 1'b1; ds_f = pos32; dl_f = len_n;
					end
					ph_f = (left_n != 33'd0) ? PH_PAY : PH_CTAG;
				end
			end
			PH_PAY: begin
				if (kind_q == K_FMT && len_q >= 32'd16 && !idx_sat_q) begin
					case (idx_q)
						4'd0: fv_f[7:0] = byte_in;
						4'd1: fv_f[15:8] = byte_in;
						4'd2: ch_f[7:0] = byte_in;
						4'd3: ch_f[15:8] = byte_in;
						4'd4: rt_f[7:0] = byte_in;
						4'd5: rt_f[15:8] = byte_in;
						4'd6: rt_f[23:16] = byte_in;
						4'd7: rt_f[31:24] = byte_in;
						4'd14: bt_f[7:0] = byte_in;
						4'd15: bt_f[15:8] = byte_in;
						default: ;
					endcase
				end
				lf_f = left_q - 33'd1;
				if (lf_f == 33'd0) ph_f = PH_CTAG;
			end
			default: ph_f = PH_RIFF;
		endcase
	end

	logic [2:0] st;
	always_comb begin
		if (ph_f == PH_RIFF || ph_f == PH_RSIZE || ph_f == PH_WAVE) st = wrhp_pkg::ST_SMALL;
		else if (err_f != wrhp_pkg::ST_OK) st = err_f;
		else if (ph_f == PH_PAY && lf_f > {32'd0, ln_f[0]}) st = wrhp_pkg::ST_OVERFLOW;
		else if (!fmt_f || !data_f) st = wrhp_pkg::ST_MISSING;
		else if (fv_f != exp_format || ch_f != exp_channels || rt_f != exp_rate
			|| bt_f != exp_bits) st = wrhp_pkg::ST_UNSUP;
		else if (dl_f == 32'd0) st = wrhp_pkg::ST_DATA;
		else st = wrhp_pkg::ST_OK;
	end

	logic ok;
	assign ok = (st == wrhp_pkg::ST_OK);
	always_comb begin
		res.accepted = ok;
		res.status = st;
		res.audio_format = ok ? fv_f : 16'd0;
		res.channel_count = ok ? ch_f : 16'd0;
		res.sample_rate = ok ? rt_f : 32'd0;
		res.sample_bits = ok ? bt_f : 16'd0;
		res.payload_offset = ok ? ds_f : 32'd0;
		res.payload_size = ok ? dl_f : 32'd0;
	end
	assign res_push = in_valid && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF; kind_q <= K_OTHER; fcnt_q <= '0; tag_q <= '0;
			len_q <= '0; left_q <= '0; idx_q <= '0; idx_sat_q <= 1'b0;
			fmt_q <= 1'b0; data_q <= 1'b0; fmt_v_q <= '0; ch_q <= '0;
			bits_q <= '0; rate_q <= '0; dstart_q <= '0; dlen_q <= '0;
			err_q <= '0; pos_q <= '0;
		end else if (in_valid) begin
			if (last_byte) begin
				phase_q <= PH_RIFF; kind_q <= K_OTHER; fcnt_q <= '0; tag_q <= '0;
				len_q <= '0; left_q <= '0; idx_q <= '0; idx_sat_q <= 1'b0;
				fmt_q <= 1'b0; data_q <= 1'b0; fmt_v_q <= '0; ch_q <= '0;
				bits_q <= '0; rate_q <= '0; dstart_q <= '0; dlen_q <= '0;
				err_q <= '0; pos_q <= '0;
			end else begin
				phase_q <= ph_f; err_q <= err_f; fmt_q <= fmt_f; data_q <= data_f;
				fmt_v_q <= fv_f; ch_q <= ch_f; rate_q <= rt_f; bits_q <= bt_f;
				dstart_q <= ds_f; dlen_q <= dl_f; len_q <= ln_f; left_q <= lf_f;
				pos_q <= pos_n;
				if (phase_q != PH_PAY) fcnt_q <= fcnt_q + 2'd1;
				if (phase_q == PH_RIFF || phase_q == PH_WAVE || phase_q == PH_CTAG)
					tag_q <= tag_n;
				if (phase_q == PH_CTAG && fcnt_q == 2'd3) begin
					kind_q <= (tag_n == wrhp_pkg::TAG_FMT) ? K_FMT :
						(tag_n == wrhp_pkg::TAG_DATA) ? K_DATA : K_OTHER;
				end
				if (phase_q == PH_CSIZE) begin
					idx_q <= '0; idx_sat_q <= 1'b0;
				end else if (phase_q == PH_PAY) begin
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'd15) idx_sat_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/wrhp_queue.sv =====
// Two-entry result queue between the parser and the output channel.
module wrhp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wrhp_pkg::result_t din,
	output logic              full,
	output wrhp_pkg::link_t   link,
	input  logic              out_stall,
	output wrhp_pkg::result_t dout
);

	wrhp_pkg::result_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic pop;

	assign pop = (cnt_q != 2'd0) && !out_stall;
	assign full = (cnt_q == 2'd2);
	assign link.valid = (cnt_q != 2'd0);
	assign link.stall = out_stall;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== design/wav_riff_header_parser.sv =====
// Top level of the WAV RIFF header parser.
// One byte is taken per cycle while in_stall is low; a beat with last_byte set yields one
// result that is written into a two-entry queue and offered once the results ahead of it are taken.
// in_stall rises only while the queue holds two results the output side has not
// taken, and while it is high every beat waits, not only one with last_byte set.
module wav_riff_header_parser #(
	parameter int OFFSET_BITS = wrhp_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_in,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [2:0]  status,
	output logic [15:0] audio_format,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [15:0] sample_bits,
	output logic [31:0] payload_offset,
	output logic [31:0] payload_size,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [15:0] exp_format_q, exp_channels_q, exp_bits_q;
	logic [31:0] exp_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_format_q <= 16'd1; exp_channels_q <= 16'd1;
			exp_rate_q <= 32'd24000; exp_bits_q <= 16'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				wrhp_pkg::REG_FORMAT:   exp_format_q <= cfg_data[15:0];
				wrhp_pkg::REG_CHANNELS: exp_channels_q <= cfg_data[15:0];
				wrhp_pkg::REG_RATE:     exp_rate_q <= cfg_data;
				wrhp_pkg::REG_BITS:     exp_bits_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic full, push, take;
	wrhp_pkg::result_t res, dout;
	wrhp_pkg::link_t link;

	assign in_stall = full;
	assign take = in_valid && !full;

	wrhp_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
		.clk, .arst_n, .in_valid(take), .byte_in, .last_byte,
		.exp_format(exp_format_q), .exp_channels(exp_channels_q),
		.exp_rate(exp_rate_q), .exp_bits(exp_bits_q),
		.res, .res_push(push)
	);

	wrhp_queue u_queue (
		.clk, .arst_n, .push, .din(res), .full, .link, .out_stall, .dout
	);

	assign out_valid = link.valid;
	assign accepted = dout.accepted;
	assign status = dout.status;
	assign audio_format = dout.audio_format;
	assign channel_count = dout.channel_count;
	assign sample_rate = dout.sample_rate;
	assign sample_bits = dout.sample_bits;
	assign payload_offset = dout.payload_offset;
	assign payload_size = dout.payload_size;

	a_acc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (accepted == (status == wrhp_pkg::ST_OK))) else $error("accepted mismatch");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> (payload_size == 32'd0 && sample_rate == 32'd0))
		else $error("failed result carries fields");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid) else $error("input stalled with empty queue");

endmodule

// ===== test/wav_riff_header_parser_test.sv =====
// Self-checking testbench for the WAV RIFF header parser: directed and random byte streams.
module wav_riff_header_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	class wav_scoreboard;
		wrhp_pkg::result_t pending[$];
		int errors;
		int shown;

		function void note(wrhp_pkg::result_t r);
			pending.push_back(r);
		endfunction

		function void check(wrhp_pkg::result_t got);
			wrhp_pkg::result_t want;
			if (pending.size() == 0) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result %h", got);
				end
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (shown < 10) begin
					shown++;
					$display("mismatch: expected acc=%b st=%0d fmt=%h ch=%h rate=%h bits=%h off=%h size=%h",
						want.accepted, want.status, want.audio_format, want.channel_count,
						want.sample_rate, want.sample_bits, want.payload_offset, want.payload_size);
					$display("          actual   acc=%b st=%0d fmt=%h ch=%h rate=%h bits=%h off=%h size=%h",
						got.accepted, got.status, got.audio_format, got.channel_count,
						got.sample_rate, got.sample_bits, got.payload_offset, got.payload_size);
				end
			end
		endfunction
	endclass

	typedef enum logic [2:0] {
		P_RIFF, P_RSIZE, P_WAVE, P_CTAG, P_CSIZE, P_PAY
	} phase_t;
	typedef enum logic [1:0] {K_OTHER, K_FMT, K_DATA} kind_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0, cfg_we = 0;
	logic [7:0] byte_in = 0;
	logic last_byte = 0;
	logic [1:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic in_stall, out_valid, accepted;
	logic [2:0] status;
	logic [15:0] audio_format, channel_count, sample_bits;
	logic [31:0] sample_rate, payload_offset, payload_size;

	wav_riff_header_parser u_top (.*);

	always #5 clk = ~clk;

	wav_scoreboard sb = new();

	logic [15:0] want_fmt = 1, want_ch = 1, want_bits = 16;
	logic [31:0] want_rate = 24000;

	phase_t ph;
	kind_t kind;
	logic [31:0] pos, shreg, clen, dstart, dlen, rate_c;
	logic [32:0] left;
	logic [2:0] fcnt, err;
	logic hfmt, hdata;
	logic [15:0] fmt_c, ch_c, bits_c;

	logic [7:0] stream_b[$];
	logic stream_l[$];
	bit hold_long;

	task automatic clear_parse();
		ph = P_RIFF; kind = K_OTHER; pos = 0; shreg = 0; clen = 0; left = 0;
		fcnt = 0; err = 0; hfmt = 0; hdata = 0; fmt_c = 0; ch_c = 0; bits_c = 0;
		rate_c = 0; dstart = 0; dlen = 0;
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic lst);
		logic [32:0] idx;
		logic [2:0] st;
		wrhp_pkg::result_t r;
		case (ph)
			P_RIFF, P_WAVE, P_CTAG: begin
				shreg = {shreg[23:0], b};
				fcnt++;
				if (fcnt == 4) begin
					fcnt = 0;
					if (ph == P_RIFF) begin
						if (shreg != wrhp_pkg::TAG_RIFF && err == 0) err = wrhp_pkg::ST_MAGIC;
						ph = P_RSIZE;
					end else if (ph == P_WAVE) begin
						if (shreg != wrhp_pkg::TAG_WAVE && err == 0) err = wrhp_pkg::ST_MAGIC;
						ph = P_CTAG;
					end else begin
						kind = shreg == wrhp_pkg::TAG_FMT ? K_FMT :
							shreg == wrhp_pkg::TAG_DATA ? K_DATA : K_OTHER;
						clen = 0;
						ph = P_CSIZE;
					end
				end
			end
			P_RSIZE: begin
				fcnt++;
				if (fcnt == 4) begin
					fcnt = 0;
					ph = P_WAVE;
				end
			end
			P_CSIZE: begin
				clen = {b, clen[31:8]};
				fcnt++;
				if (fcnt == 4) begin
					fcnt = 0;
					left = {1'b0, clen} + {32'd0, clen[0]};
					if (kind == K_FMT) begin
						if (clen < 16) begin
							if (err == 0) err = wrhp_pkg::ST_FMT;
						end else hfmt = 1;
					end else if (kind == K_DATA) begin
						hdata = 1;
						dstart = pos + 1;
						dlen = clen;
					end
					ph = left != 0 ? P_PAY : P_CTAG;
				end
			end
			P_PAY: begin
				idx = {1'b0, clen} + {32'd0, clen[0]} - left;
				if (kind == K_FMT && clen >= 16 && idx < 16) begin
					case (idx[3:0])
						0: fmt_c[7:0] = b;
						1: fmt_c[15:8] = b;
						2: ch_c[7:0] = b;
						3: ch_c[15:8] = b;
						4: rate_c[7:0] = b;
						5: rate_c[15:8] = b;
						6: rate_c[23:16] = b;
						7: rate_c[31:24] = b;
						14: bits_c[7:0] = b;
						15: bits_c[15:8] = b;
						default: ;
					endcase
				end
				left--;
				if (left == 0) ph = P_CTAG;
			end
			default: begin
				ph = P_RIFF;
				fcnt = 0;
			end
		endcase
		pos++;
		if (!lst) return;
		if (ph == P_RIFF || ph == P_RSIZE || ph == P_WAVE) st = wrhp_pkg::ST_SMALL;
		else if (err != 0) st = err;
		else if (ph == P_PAY && left > {32'd0, clen[0]}) st = wrhp_pkg::ST_OVERFLOW;
		else if (!hfmt || !hdata) st = wrhp_pkg::ST_MISSING;
		else if (fmt_c != want_fmt || ch_c != want_ch || rate_c != want_rate ||
			bits_c != want_bits) st = wrhp_pkg::ST_UNSUP;
		else if (dlen == 0) st = wrhp_pkg::ST_DATA;
		else st = wrhp_pkg::ST_OK;
		r = '0;
		r.status = st;
		if (st == wrhp_pkg::ST_OK) begin
			r.accepted = 1;
			r.audio_format = fmt_c; r.channel_count = ch_c; r.sample_rate = rate_c;
			r.sample_bits = bits_c; r.payload_offset = dstart; r.payload_size = dlen;
		end
		sb.note(r);
		clear_parse();
	endtask

	task automatic push(input logic [7:0] b, input logic l = 0);
		stream_b.push_back(b);
		stream_l.push_back(l);
	endtask

	task automatic push32(input logic [31:0] v);
		for (int i = 0; i < 4; i++) push(v[8*i +: 8]);
	endtask

	task automatic push_tag(input logic [31:0] t);
		for (int i = 3; i >= 0; i--) push(t[8*i +: 8]);
	endtask

	task automatic end_stream();
		stream_l[stream_l.size() - 1] = 1;
	endtask

	// well-formed-ish file with random content and optional damage
	task automatic build_file(input bit noisy);
		int nchunks, n, k, sz;
		logic [31:0] t;
		push_tag($urandom_range(0, 9) == 0 ? $urandom : wrhp_pkg::TAG_RIFF);
		push32($urandom);
		push_tag($urandom_range(0, 9) == 0 ? $urandom : wrhp_pkg::TAG_WAVE);
		nchunks = $urandom_range(0, 3);
		for (int c = 0; c < nchunks; c++) begin
			k = $urandom_range(0, 3);
			t = k == 0 ? $urandom : (k == 1 || k == 3) ? wrhp_pkg::TAG_FMT : wrhp_pkg::TAG_DATA;
			if (t == wrhp_pkg::TAG_FMT)
				sz = $urandom_range(0, 7) == 0 ? $urandom_range(0, 15) : $urandom_range(16, 19);
			else sz = $urandom_range(0, 9);
			push_tag(t);
			push32(sz);
			for (int i = 0; i < sz + sz % 2; i++) begin
				if (t == wrhp_pkg::TAG_FMT && $urandom_range(0, 3) != 0) begin
					case (i)
						0: push(want_fmt[7:0]);
						1: push(want_fmt[15:8]);
						2: push(want_ch[7:0]);
						3: push(want_ch[15:8]);
						4, 5, 6, 7: push(want_rate[8*(i-4) +: 8]);
						14: push(want_bits[7:0]);
						15: push(want_bits[15:8]);
						default: push(8'($urandom));
					endcase
				end else push(8'($urandom));
			end
		end
		if (noisy) begin
			n = $urandom_range(0, 6);
			for (int i = 0; i < n; i++) push(8'($urandom));
			if ($urandom_range(0, 1)) begin
				push_tag(wrhp_pkg::TAG_DATA);
				push32($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom_range(5, 40));
				push(8'($urandom));
			end
		end
		end_stream();
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [31:0] v);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			wrhp_pkg::REG_FORMAT: want_fmt = v[15:0];
			wrhp_pkg::REG_CHANNELS: want_ch = v[15:0];
			wrhp_pkg::REG_RATE: want_rate = v;
			wrhp_pkg::REG_BITS: want_bits = v[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_stream();
		int gap;
		while (stream_b.size() > 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 2) == 0) gap = 0;
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1;
			byte_in <= stream_b[0];
			last_byte <= stream_l[0];
			do @(posedge clk); while (in_stall);
			parse_byte(stream_b[0], stream_l[0]);
			void'(stream_b.pop_front());
			void'(stream_l.pop_front());
		end
		in_valid <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			sb.check({accepted, status, audio_format, channel_count, sample_rate, sample_bits,
				payload_offset, payload_size});
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				hold_long = 0;
			end
			gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
			if (gap != 0) begin
				out_stall <= 1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
		end
	end

	int idle = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle <= 0;
		else idle <= idle + 1;
		if (idle > 5000) begin
			$display("wav_riff_header_parser_test: done, errors");
			$finish;
		end
	end

	initial begin
		clear_parse();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: minimal valid file, short buffer
		push_tag(wrhp_pkg::TAG_RIFF); push32(0); push_tag(wrhp_pkg::TAG_WAVE);
		push_tag(wrhp_pkg::TAG_FMT); push32(16);
		push32(32'h0001_0001); push32(24000); push32(0); push32(32'h0010_0000);
		push_tag(wrhp_pkg::TAG_DATA); push32(1); push(8'hFF); push(8'h00, 1);
		push(8'h00); push(8'hFF, 1);
		build_file(0);
		send_stream();
		drain();
		set_reg(wrhp_pkg::REG_FORMAT, 32'h0000_FFFF); set_reg(wrhp_pkg::REG_CHANNELS, 32'h0);
		set_reg(wrhp_pkg::REG_RATE, 32'hFFFF_FFFF); set_reg(wrhp_pkg::REG_BITS, 32'h0000_FFFF);
		for (int i = 0; i < 6; i++) build_file(1);
		send_stream();
		drain();
		set_reg(wrhp_pkg::REG_FORMAT, 32'h0); set_reg(wrhp_pkg::REG_CHANNELS, 32'h0000_FFFF);
		set_reg(wrhp_pkg::REG_RATE, 32'h0); set_reg(wrhp_pkg::REG_BITS, 32'h0);
		hold_long = 1;
		for (int i = 0; i < 8; i++) push(8'hA5, 1);
		send_stream();
		drain();
		for (int ph_i = 0; ph_i < 4; ph_i++) begin
			set_reg(wrhp_pkg::REG_FORMAT, $urandom_range(0, 3));
			set_reg(wrhp_pkg::REG_CHANNELS, $urandom_range(1, 2));
			set_reg(wrhp_pkg::REG_RATE, $urandom_range(0, 1) ? 48000 : $urandom);
			set_reg(wrhp_pkg::REG_BITS, $urandom_range(0, 1) ? 16 : $urandom);
			while (stream_b.size() < 200) build_file($urandom_range(0, 3) == 0);
			send_stream();
			drain();
		end
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("wav_riff_header_parser_test: done, clean");
		else
			$display("wav_riff_header_parser_test: done, errors");
		$finish;
	end
endmodule
